// File: src/recb_pkg.sv
// shared types, codes and step-count helper for the rotary encoder and button control
package recb_pkg;

    localparam int PUSH_DEBOUNCE_TICKS_DEF = 20;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2,
        DIR_ODD  = 2'd3
    } recb_dir_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } recb_event_t;

    typedef enum logic [2:0] {
        REG_DUAL_MODE    = 3'd0,
        REG_ATT_STEPS    = 3'd1,
        REG_CHAN_STEPS   = 3'd2,
        REG_MAX_ATT      = 3'd3,
        REG_MAX_CHAN     = 3'd4,
        REG_DEBOUNCE     = 3'd5,
        REG_LONG_PRESS   = 3'd6,
        REG_DOUBLE_CLICK = 3'd7
    } recb_reg_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_ticks;
    } recb_btn_cfg_t;

    typedef struct packed {
        logic signed [4:0] count;
        recb_dir_t         last;
        logic signed [1:0] unit;
    } recb_step_t;

    function automatic recb_step_t recb_count_step(logic signed [4:0] count,
                                                    recb_dir_t last,
                                                    recb_dir_t dir,
                                                    logic [3:0] steps);
        recb_step_t        res;
        logic signed [5:0] c;
        logic signed [5:0] lim;
        c = (last != dir) ? 6'sd0 : 6'(count);
        lim = signed'({2'b00, steps});
        if (dir == DIR_CW) begin
            c = c + 6'sd1;
        end else if (dir == DIR_CCW) begin
            c = c - 6'sd1;
        end
        res.last = dir;
        if (c >= lim) begin
            res.count = 5'sd0;
            res.unit = 2'sd1;
        end else if (c <= -lim) begin
            res.count = 5'sd0;
            res.unit = -2'sd1;
        end else begin
            res.count = c[4:0];
            res.unit = 2'sd0;
        end
        return res;
    endfunction

endpackage

// File: src/recb_button.sv
// click classifier for one push button: single, double and long press
module recb_button (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   level,
    input  logic [15:0]            tick,
    input  recb_pkg::recb_btn_cfg_t cfg,
    output recb_pkg::recb_event_t  event_code
);
    import recb_pkg::*;

    logic        down_reg, down_next;
    logic        await_reg, await_next;
    logic [15:0] press_reg, press_next;
    logic [15:0] release_reg, release_next;
    logic [1:0]  tally_reg, tally_next;
    logic [15:0] dur;
    logic [15:0] since;

    always_comb begin
        down_next = down_reg;
        await_next = await_reg;
        press_next = press_reg;
        release_next = release_reg;
        tally_next = tally_reg;
        event_code = EV_NONE;
        dur = tick - press_reg;
        if (!level) begin
            if (!down_reg) begin
                press_next = tick;
                down_next = 1'b1;
            end
        end else if (down_reg) begin
            down_next = 1'b0;
            if (dur >= cfg.debounce_ticks) begin
                release_next = tick;
                if (dur >= cfg.long_press_ticks) begin
                    event_code = EV_LONG;
                    tally_next = 2'd0;
                    await_next = 1'b0;
                end else begin
                    if (tally_reg != 2'd3) begin
                        tally_next = tally_reg + 2'd1;
                    end
                    await_next = 1'b1;
                end
            end
        end
        since = tick - release_next;
        if (await_next && (since > cfg.double_click_ticks)) begin
            if (tally_next == 2'd1) begin
                event_code = EV_SINGLE;
            end else if (tally_next == 2'd2) begin
                event_code = EV_DOUBLE;
            end
            tally_next = 2'd0;
            await_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg <= 1'b0;
            await_reg <= 1'b0;
            press_reg <= '0;
            release_reg <= '0;
            tally_reg <= '0;
        end else if (step_en) begin
            down_reg <= down_next;
            await_reg <= await_next;
            press_reg <= press_next;
            release_reg <= release_next;
            tally_reg <= tally_next;
        end
    end

    // a pending click sequence always holds at least one click
    a_await_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg == (tally_reg != 2'd0))
        else $error("click tally and pending timeout disagree");

endmodule

// File: src/rotary_encoder_button_control.sv
// top level: encoder detent counting, attenuation/channel control, button and push handling
//
//  channel   ports                          word contents (lsb first)
//  input     s_tvalid s_tready s_tdata      dir_one, dir_two, switch_one_level,
//            s_tuser                        switch_two_level, push_ack | single_target
//  result    m_tvalid m_tready m_tdata      attenuation, channel, button_one_event,
//                                           button_two_event, push_pending
//  config    cfg_valid cfg_ready            cfg_index (register), cfg_data (value)
//
//  one tick word per cycle while s_tready is high; the result is in m_tdata
//  the cycle after acceptance; a single result register decouples the sides;
//  s_tready drops only while it holds a word that m_tready does not take
//  cfg_ready is always high; registers return to their defaults on aresetn low
//  aresetn is synchronous and clears all tick state and the result valid
module rotary_encoder_button_control #(
    parameter int PUSH_DEBOUNCE_TICKS = recb_pkg::PUSH_DEBOUNCE_TICKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [recb_pkg::S_TDATA_W-1:0]   s_tdata,  // dir_one[1:0], dir_two[3:2],
                                                       // switch_one_level[4],
                                                       // switch_two_level[5],
                                                       // push_ack[6], zero[7]
    input  logic                             s_tuser,  // single_target[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [recb_pkg::M_TDATA_W-1:0]   m_tdata,  // attenuation[7:0], channel[11:8],
                                                       // button_one_event[13:12],
                                                       // button_two_event[15:14],
                                                       // push_pending[16], zero[23:17]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [recb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [recb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import recb_pkg::*;

    localparam int HOLD_W = $clog2(PUSH_DEBOUNCE_TICKS + 1);

    // configuration
    logic          dual_mode_reg;
    logic [3:0]    att_steps_reg;
    logic [3:0]    chan_steps_reg;
    logic [7:0]    max_att_reg;
    logic [3:0]    max_chan_reg;
    recb_btn_cfg_t btn_cfg_reg;

    // tick state
    logic signed [4:0] cnt_reg [4];
    logic signed [4:0] cnt_next [4];
    recb_dir_t         last_reg [3];
    recb_dir_t         last_next [3];
    logic [7:0]        att_reg, att_next;
    logic [3:0]        chan_reg, chan_next;
    logic [15:0]       tick_reg, tick_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              qual_reg, qual_next;
    logic              push_reg, push_next;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic        accept;
    recb_dir_t   dir_one, dir_two;
    logic        sw_one, sw_two, push_ack, single_target;
    recb_event_t ev_one, ev_two;
    recb_event_t ev_one_res, ev_two_res;
    logic        btn_en;

    assign dir_one       = recb_dir_t'(s_tdata[1:0]);
    assign dir_two       = recb_dir_t'(s_tdata[3:2]);
    assign sw_one        = s_tdata[4];
    assign sw_two        = s_tdata[5];
    assign push_ack      = s_tdata[6];
    assign single_target = s_tuser;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;
    assign btn_en    = accept && dual_mode_reg;

    // buttons report nothing in single mode
    assign ev_one_res = dual_mode_reg ? ev_one : EV_NONE;
    assign ev_two_res = dual_mode_reg ? ev_two : EV_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dual_mode_reg <= 1'b1;
            att_steps_reg <= 4'd2;
            chan_steps_reg <= 4'd4;
            max_att_reg <= 8'd255;
            max_chan_reg <= 4'd3;
            btn_cfg_reg.debounce_ticks <= 16'd50;
            btn_cfg_reg.long_press_ticks <= 16'd1000;
            btn_cfg_reg.double_click_ticks <= 16'd300;
        end else if (cfg_valid && cfg_ready) begin
            unique case (recb_reg_t'(cfg_index))
                REG_DUAL_MODE:    dual_mode_reg <= cfg_data[0];
                REG_ATT_STEPS:    att_steps_reg <= cfg_data[3:0];
                REG_CHAN_STEPS:   chan_steps_reg <= cfg_data[3:0];
                REG_MAX_ATT:      max_att_reg <= cfg_data[7:0];
                REG_MAX_CHAN:     max_chan_reg <= cfg_data[3:0];
                REG_DEBOUNCE:     btn_cfg_reg.debounce_ticks <= cfg_data;
                REG_LONG_PRESS:   btn_cfg_reg.long_press_ticks <= cfg_data;
                REG_DOUBLE_CLICK: btn_cfg_reg.double_click_ticks <= cfg_data;
                default:          dual_mode_reg <= dual_mode_reg;
            endcase
        end
    end

    recb_button u_button_one (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (btn_en),
        .level      (sw_one),
        .tick       (tick_next),
        .cfg        (btn_cfg_reg),
        .event_code (ev_one)
    );

    recb_button u_button_two (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (btn_en),
        .level      (sw_two),
        .tick       (tick_next),
        .cfg        (btn_cfg_reg),
        .event_code (ev_two)
    );

    always_comb begin
        recb_step_t        st;
        logic signed [9:0] av;
        logic signed [5:0] cv;
        logic [1:0]        aslot, cslot;
        logic [1:0]        dslot;
        logic              do_att, do_chan;
        recb_dir_t         adir, cdir;

        for (int i = 0; i < 4; i++) begin
            cnt_next[i] = cnt_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            last_next[i] = last_reg[i];
        end
        att_next = att_reg;
        chan_next = chan_reg;
        tick_next = tick_reg;
        hold_next = hold_reg;
        qual_next = qual_reg;
        push_next = push_reg;

        if (push_ack) begin
            push_next = 1'b0;
            hold_next = '0;
            qual_next = 1'b0;
        end

        // slot choice: dual uses counts 0/1 and directions 0/1, single uses 2/3 and 2
        if (dual_mode_reg) begin
            do_att = (dir_one != DIR_IDLE);
            do_chan = (dir_two != DIR_IDLE);
            adir = dir_one;
            cdir = dir_two;
            aslot = 2'd0;
            cslot = 2'd1;
        end else begin
            do_att = (dir_one != DIR_IDLE) && !single_target;
            do_chan = (dir_one != DIR_IDLE) && single_target;
            adir = dir_one;
            cdir = dir_one;
            aslot = 2'd2;
            cslot = 2'd3;
        end

        dslot = dual_mode_reg ? 2'd0 : 2'd2;
        st = recb_count_step(cnt_reg[aslot], last_reg[dslot], adir, att_steps_reg);
        av = 10'(signed'({2'b00, att_reg})) - 10'(st.unit);
        if (do_att) begin
            cnt_next[aslot] = st.count;
            last_next[dslot] = st.last;
            if (av > signed'({2'b00, max_att_reg})) begin
                att_next = max_att_reg;
            end else if (av < 10'sd0) begin
                att_next = 8'd0;
            end else begin
                att_next = av[7:0];
            end
        end

        dslot = dual_mode_reg ? 2'd1 : 2'd2;
        st = recb_count_step(cnt_reg[cslot], last_reg[dslot], cdir, chan_steps_reg);
        cv = 6'(signed'({2'b00, chan_reg})) + 6'(st.unit);
        if (do_chan) begin
            cnt_next[cslot] = st.count;
            last_next[dslot] = st.last;
            if (cv > signed'({2'b00, max_chan_reg})) begin
                chan_next = 4'd0;
            end else if (cv < 6'sd0) begin
                chan_next = max_chan_reg;
            end else begin
                chan_next = cv[3:0];
            end
        end

        if (dual_mode_reg) begin
            tick_next = tick_reg + 16'd1;
        end else if (!push_next) begin
            if (!sw_one) begin
                if (hold_next != '1) begin
                    hold_next = hold_next + HOLD_W'(1);
                end
                qual_next = (hold_next >= HOLD_W'(PUSH_DEBOUNCE_TICKS));
            end else begin
                if (qual_next) begin
                    push_next = 1'b1;
                end
                hold_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                last_reg[i] <= DIR_IDLE;
            end
            att_reg <= '0;
            chan_reg <= '0;
            tick_reg <= '0;
            hold_reg <= '0;
            qual_reg <= 1'b0;
            push_reg <= 1'b0;
        end else if (accept) begin
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
            for (int i = 0; i < 3; i++) begin
                last_reg[i] <= last_next[i];
            end
            att_reg <= att_next;
            chan_reg <= chan_next;
            tick_reg <= tick_next;
            hold_reg <= hold_next;
            qual_reg <= qual_next;
            push_reg <= push_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {7'd0, push_next, ev_two_res, ev_one_res, chan_next, att_next};
        end
    end

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_single_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !dual_mode_reg) |-> (m_tdata[15:12] == 4'd0))
        else $error("button event reported in single mode");

    a_push_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_reg && !(accept && push_ack)) |=> push_reg)
        else $error("push flag dropped without acknowledge");

    a_tick_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !dual_mode_reg) |=> $stable(tick_reg))
        else $error("tick counter moved in single mode");

endmodule
